// ----- hw/rtl/spl_pkg.sv -----
// Shared types and constants for the sorted priority list.
// Used by spl_store and sorted_priority_list_top; depends on nothing else.
package spl_pkg;

  localparam int TAG_W  = 16;
  localparam int FARE_W = 20;
  localparam int PTS_W  = 16;
  localparam int KEY_W  = 23;
  localparam int OCC_W  = 5;
  localparam int STAT_W = 2;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [FARE_W-1:0] fare;
    logic [PTS_W-1:0]  points;
    logic [KEY_W-1:0]  key;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_PUT,
    S_REM_RD,
    S_REM_GET,
    S_RESP
  } state_t;

  // Ordering key: fare plus 100 times points, built from shifts and adds.
  function automatic logic [KEY_W-1:0] key_of(input logic [FARE_W-1:0] fare,
                                              input logic [PTS_W-1:0] pts);
    logic [KEY_W-1:0] p;
    p = KEY_W'(pts);
    return KEY_W'(fare) + (p << 6) + (p << 5) + (p << 2);
  endfunction

endpackage

// ----- hw/rtl/spl_store.sv -----
// Entry store of the sorted priority list: one write port, one registered read port.
// Depends on spl_pkg for the entry type.
module spl_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  spl_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output spl_pkg::entry_t rdata
);
  import spl_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/sorted_priority_list_top.sv -----
// Top level of the sorted priority list: sequencer, circular entry store and result register.
// Depends on spl_pkg and spl_store.
//
// The block holds up to CAPACITY entries ordered by fare_cents + 100 * loyalty_points,
// lowest first. An input item with action insert adds an entry behind all entries of
// equal key; an item with action remove takes the front entry and returns it.
// Each accepted item gives exactly one result item with status and occupancy.
// The input channel is ready only while the sequencer is idle. An insert walks the
// store from the back, one entry at a time through a single compare unit and the
// store's one write port and one registered read port, moving each entry of greater
// key back by one place. A rejected insert or an empty remove goes straight to the
// result. in_ready rises on the same edge as out_valid, so the next item can be
// accepted once the result has been loaded into the output register.
// A finished result waits in the output register while the receiver stalls; the
// block accepts the next item meanwhile and holds its own result until the output
// register frees. Reset empties the list at once; there is no clearing pass.
module sorted_priority_list_top #(
  parameter int CAPACITY = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         action,
  input  logic [spl_pkg::TAG_W-1:0]    passenger_tag,
  input  logic [spl_pkg::FARE_W-1:0]   fare_cents,
  input  logic [spl_pkg::PTS_W-1:0]    loyalty_points,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [spl_pkg::STAT_W-1:0]   status,
  output logic [spl_pkg::TAG_W-1:0]    removed_tag,
  output logic [spl_pkg::FARE_W-1:0]   removed_fare,
  output logic [spl_pkg::PTS_W-1:0]    removed_points,
  output logic [spl_pkg::OCC_W-1:0]    occupancy
);
  import spl_pkg::*;

  localparam int PTR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(CAPACITY);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? LAST : p - 1'b1;
  endfunction

  state_t            state, state_next;
  logic [PTR_W-1:0]  head, head_next;
  logic [PTR_W-1:0]  tail, tail_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  pos, pos_next;
  logic [PTR_W-1:0]  wptr, wptr_next;
  entry_t            new_ent, new_ent_next;
  logic [STAT_W-1:0] res_status, res_status_next;
  logic [TAG_W-1:0]  res_tag, res_tag_next;
  logic [FARE_W-1:0] res_fare, res_fare_next;
  logic [PTS_W-1:0]  res_points, res_points_next;
  logic              out_load;

  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic [PTR_W-1:0]  mem_raddr;
  entry_t            mem_rdata;

  spl_store #(
    .DEPTH (CAPACITY),
    .AW    (PTR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    pos_next        = pos;
    wptr_next       = wptr;
    new_ent_next    = new_ent;
    res_status_next = res_status;
    res_tag_next    = res_tag;
    res_fare_next   = res_fare;
    res_points_next = res_points;
    mem_we          = 1'b0;
    mem_waddr       = wptr;
    mem_wdata       = new_ent;
    mem_raddr       = ptr_dec(wptr);
    out_load        = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          new_ent_next.tag    = passenger_tag;
          new_ent_next.fare   = fare_cents;
          new_ent_next.points = loyalty_points;
          new_ent_next.key    = key_of(fare_cents, loyalty_points);
          res_tag_next        = '0;
          res_fare_next       = '0;
          res_points_next     = '0;
          res_status_next     = STATUS_OK;
          wptr_next           = tail;
          pos_next            = count;
          if (action == ACT_INSERT) begin
            if (count == FULL) begin
              res_status_next = STATUS_FULL;
              state_next      = S_RESP;
            end else if (count == '0) begin
              state_next = S_PUT;
            end else begin
              state_next = S_INS_RD;
            end
          end else begin
            if (count == '0) begin
              res_status_next = STATUS_EMPTY;
              state_next      = S_RESP;
            end else begin
              state_next = S_REM_RD;
            end
          end
        end
      end
      S_INS_RD: begin
        state_next = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (mem_rdata.key > new_ent.key) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          wptr_next = ptr_dec(wptr);
          pos_next  = pos - 1'b1;
          state_next = (pos == CNT_W'(1)) ? S_PUT : S_INS_RD;
        end else begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        mem_we     = 1'b1;
        mem_wdata  = new_ent;
        count_next = count + 1'b1;
        tail_next  = ptr_inc(tail);
        state_next = S_RESP;
      end
      S_REM_RD: begin
        mem_raddr  = head;
        state_next = S_REM_GET;
      end
      S_REM_GET: begin
        mem_raddr       = head;
        res_tag_next    = mem_rdata.tag;
        res_fare_next   = mem_rdata.fare;
        res_points_next = mem_rdata.points;
        head_next       = ptr_inc(head);
        count_next      = count - 1'b1;
        state_next      = S_RESP;
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    wptr       <= wptr_next;
    new_ent    <= new_ent_next;
    res_status <= res_status_next;
    res_tag    <= res_tag_next;
    res_fare   <= res_fare_next;
    res_points <= res_points_next;
    if (out_load) begin
      status         <= res_status;
      removed_tag    <= res_tag;
      removed_fare   <= res_fare;
      removed_points <= res_points;
      occupancy      <= OCC_W'(count);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("Entry count exceeds capacity.");

  a_empty_remove: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == ACT_REMOVE && count == '0)
      |=> (state == S_RESP && res_status == STATUS_EMPTY))
    else $error("Remove from an empty list did not report empty.");

  a_walk_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_CMP) |-> (pos != '0))
    else $error("Insert walk compared past the front of the list.");

  a_full_no_write: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == ACT_INSERT && count == FULL)
      |=> (state == S_RESP && res_status == STATUS_FULL && $stable(count)))
    else $error("Insert into a full list changed the list.");

endmodule
